// ===== src/frame_crc16_validator_top_macros.svh =====
`ifndef FRAME_CRC16_VALIDATOR_TOP_MACROS_SVH
`define FRAME_CRC16_VALIDATOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define FCV_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FCV_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fcv_pkg.sv =====
package fcv_pkg;

  localparam int unsigned POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [4:0] MAX_LEN_OFFSET = 5'd17;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [POS_W-1:0] CRC_END_BIAS = 17'd18;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HEAD  = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_BAD_TAIL  = 3'd3;
  localparam logic [2:0] ST_CRC       = 3'd4;

  localparam logic [1:0] REG_HEAD_FLAG  = 2'd0;
  localparam logic [1:0] REG_TAIL_FLAG  = 2'd1;
  localparam logic [1:0] REG_LEN_OFFSET = 2'd2;
  localparam logic [1:0] REG_LEN_BIG_END = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload_length;
    logic [15:0] computed_crc;
  } out_word_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/frame_crc16_validator_top.sv =====
// channel  | ports                                      | direction
// ---------+--------------------------------------------+----------
// input    | in_valid, in_ready, in_data                | in
// result   | out_valid, out_ready, out_data             | out
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data  | in
//
// one byte accepted per cycle while no last byte waits on a full result register;
// the input register feeds crc and checks into the result register
// the byte-wise crc update (eight unrolled shift steps) sets the cycle time
// rst_n is synchronous and clears control and per-buffer state
// a stalled result holds only last bytes back; other bytes keep flowing
`include "frame_crc16_validator_top_macros.svh"

module frame_crc16_validator_top
  import fcv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] head_flag_r;
  logic [7:0] tail_flag_r;
  logic [4:0] len_off_r;
  logic       len_be_r;

  logic       s1_vld_r;
  in_word_t   s1_r;
  logic       s1_move;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic        head_ok_r, head_ok_nxt;
  logic        tail_ok_r, tail_ok_nxt;

  logic        out_vld_r;
  out_word_t   out_r, out_nxt;

  logic [4:0]       off;
  logic [POS_W-1:0] off_ext;
  logic [POS_W-1:0] len_ext;
  logic [POS_W-1:0] end18, end19, end20, end21;
  logic [7:0]       b;
  logic             out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || out_ready;
  assign s1_move   = s1_vld_r && (!s1_r.last_of_buffer || out_free);
  assign in_ready  = !s1_vld_r || s1_move;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_flag_r <= 8'd0;
      tail_flag_r <= 8'd0;
      len_off_r   <= 5'd1;
      len_be_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEAD_FLAG:   head_flag_r <= cfg_data;
        REG_TAIL_FLAG:   tail_flag_r <= cfg_data;
        REG_LEN_OFFSET:  len_off_r   <= cfg_data[4:0];
        REG_LEN_BIG_END: len_be_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
  end

  always_comb begin
    b       = s1_r.data_byte;
    off     = (len_off_r > MAX_LEN_OFFSET) ? MAX_LEN_OFFSET : len_off_r;
    off_ext = {{(POS_W-5){1'b0}}, off};

    head_ok_nxt = (pos_r == '0) ? (b == head_flag_r) : head_ok_r;

    len_nxt = len_r;
    if (pos_r == off_ext) begin
      if (len_be_r) begin
        len_nxt[15:8] = b;
      end else begin
        len_nxt[7:0] = b;
      end
    end
    if (pos_r == off_ext + 17'd1) begin
      if (len_be_r) begin
        len_nxt[7:0] = b;
      end else begin
        len_nxt[15:8] = b;
      end
    end

    len_ext = {1'b0, len_nxt};
    end18   = len_ext + CRC_END_BIAS;
    end19   = len_ext + 17'd19;
    end20   = len_ext + 17'd20;
    end21   = len_ext + 17'd21;

    crc_nxt = crc_r;
    if (pos_r != '0 && (pos_r <= CRC_END_BIAS || pos_r <= end18)) begin
      crc_nxt = crc16_byte(crc_r, b);
    end

    rx_crc_nxt = rx_crc_r;
    if (pos_r == end19) begin
      rx_crc_nxt[7:0] = b;
    end
    if (pos_r == end20) begin
      rx_crc_nxt[15:8] = b;
    end

    tail_ok_nxt = (pos_r == end21) ? (b == tail_flag_r) : tail_ok_r;

    pos_nxt = (pos_r != POS_MAX) ? pos_r + 17'd1 : pos_r;

    out_nxt.computed_crc   = crc_nxt;
    out_nxt.payload_length = (pos_r > off_ext) ? len_nxt : 16'd0;
    if (!head_ok_nxt) begin
      out_nxt.status = ST_BAD_HEAD;
    end else if (end21 > pos_r) begin
      out_nxt.status = ST_TRUNCATED;
    end else if (!tail_ok_nxt) begin
      out_nxt.status = ST_BAD_TAIL;
    end else if (rx_crc_nxt != crc_nxt) begin
      out_nxt.status = ST_CRC;
    end else begin
      out_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      crc_r     <= CRC_INIT;
      len_r     <= 16'd0;
      rx_crc_r  <= 16'd0;
      head_ok_r <= 1'b0;
      tail_ok_r <= 1'b0;
    end else if (s1_move) begin
      if (s1_r.last_of_buffer) begin
        pos_r     <= '0;
        crc_r     <= CRC_INIT;
        len_r     <= 16'd0;
        rx_crc_r  <= 16'd0;
        head_ok_r <= 1'b0;
        tail_ok_r <= 1'b0;
      end else begin
        pos_r     <= pos_nxt;
        crc_r     <= crc_nxt;
        len_r     <= len_nxt;
        rx_crc_r  <= rx_crc_nxt;
        head_ok_r <= head_ok_nxt;
        tail_ok_r <= tail_ok_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_move && s1_r.last_of_buffer) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_r.last_of_buffer) begin
      out_r <= out_nxt;
    end
  end

  `FCV_CHECK_NEXT(a_restart_after_last, s1_move && s1_r.last_of_buffer, pos_r == '0, "position not cleared after last word")
  `FCV_CHECK_NOW(a_crc_init_at_start, pos_r == '0, crc_r == CRC_INIT, "crc not at init at buffer start")
  `FCV_CHECK_NOW(a_status_range, out_vld_r, out_r.status <= ST_CRC, "status code out of range")
  `FCV_CHECK_NEXT(a_pos_saturates, pos_r == POS_MAX, pos_r == POS_MAX || pos_r == '0, "position wrapped")
  `FCV_CHECK_NOW(a_last_held_on_stall, s1_vld_r && s1_r.last_of_buffer && !out_free, !in_ready, "last word passed a full result register")

endmodule
